>>> design/i2cpg_pkg.sv
// ----------------------------------------------------------------------------
// i2cpg_pkg
// Shared types, constants and helpers for the im2col patch gather block.
// ----------------------------------------------------------------------------
package i2cpg_pkg;

  localparam int MAX_PLANES = 4;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_KERNEL = 16;
  localparam int MAX_OUT_W  = 64;
  localparam int DATA_WIDTH = 16;

  // Field widths of the item and result ports.
  localparam int PLANE_W = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int YOUT_W  = 7;
  localparam int KER_W   = 4;
  localparam int STEP_W  = 5;
  localparam int SIZE_W  = 7;
  localparam int XOUT_W  = 6;

  // Pixel store addressing: {plane, row, col}.
  localparam int STORE_DEPTH = MAX_PLANES * MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Signed position arithmetic. Rows: y*stride_h + kh - pad_h.
  localparam int PROD_W = YOUT_W + STEP_W;
  localparam int POS_W  = PROD_W + 1;

  // Command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    CFG_STRIDE_W  = 3'd0,
    CFG_STRIDE_H  = 3'd1,
    CFG_PAD_W     = 3'd2,
    CFG_PAD_H     = 3'd3,
    CFG_IN_WIDTH  = 3'd4,
    CFG_IN_HEIGHT = 3'd5,
    CFG_OUT_WIDTH = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_REQ  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [STEP_W-1:0] stride_w;
    logic [STEP_W-1:0] stride_h;
    logic [STEP_W-1:0] pad_w;
    logic [STEP_W-1:0] pad_h;
    logic [SIZE_W-1:0] in_width;
    logic [SIZE_W-1:0] in_height;
    logic [SIZE_W-1:0] out_width;
  } cfg_t;

  // One queued command. For a load, row/col/data give the pixel to write.
  // For a request, row is the input row, row_ok says it lies inside the
  // image, and kw is the kernel column offset.
  typedef struct packed {
    kind_e                  kind;
    logic [PLANE_W-1:0]     plane;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic signed [DATA_WIDTH-1:0] data;
    logic                   row_ok;
    logic [KER_W-1:0]       kw;
  } cmd_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Limit a size register to a maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int                lim);
    logic [SIZE_W-1:0] l;
    l = SIZE_W'(lim);
    return (v < l) ? v : l;
  endfunction

endpackage

>>> design/im2col_patch_gather.sv
// ----------------------------------------------------------------------------
// im2col_patch_gather
// Stores a four-plane 64 x 64 feature map and serves convolution patch rows.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_valid_i/in_ready_o channel. A load item
// (kind_i low) writes pixel_value_i at plane_i, pixel_row_i, pixel_col_i;
// loads outside the configured image size are taken and dropped. A request
// item (kind_i high) produces out_width results, 64 at most, on the
// out_valid_o/out_ready_i channel, one per output column, each carrying
// the gathered pixel or zero in the padding, its column index and a last
// flag on the final one.
// Timing. A request is first taken from the command queue and then issues
// one store read per cycle while the output is not stalled; the
// single-ported read of the pixel store sets that rate. Each result passes
// through the read stage and the output register. A queue of four commands
// lets the input side keep taking items while a row is being produced.
// Stalls. When the receiver holds out_ready_i low, the output register and
// the read stage hold their items and the column walk pauses; once the queue
// fills, in_ready_o drops. Nothing is lost or repeated.
// Reset. rst_ni clears the queue, the control state and the configuration
// registers to their defaults; the pixel store is not cleared, and a pixel
// must be loaded before any request reads it. Configuration writes through
// cfg_we_i, cfg_idx_i and cfg_data_i take effect at once and are meant for
// times when no item is in flight.
// ----------------------------------------------------------------------------
module im2col_patch_gather
  import i2cpg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [SIZE_W-1:0]            cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [PLANE_W-1:0]           plane_i,
  input  logic [ROW_W-1:0]             pixel_row_i,
  input  logic [COL_W-1:0]             pixel_col_i,
  input  logic signed [DATA_WIDTH-1:0] pixel_value_i,
  input  logic [YOUT_W-1:0]            out_row_i,
  input  logic [KER_W-1:0]             kernel_row_i,
  input  logic [KER_W-1:0]             kernel_col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic [XOUT_W-1:0]            out_col_o,
  output logic                         last_o
);

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_pop;
  q_head_t q_head;

  // Front end: configuration, classification and the input row of requests.
  i2cpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_o         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .plane_i       (plane_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_value_i (pixel_value_i),
    .out_row_i     (out_row_i),
    .kernel_row_i  (kernel_row_i),
    .kernel_col_i  (kernel_col_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  // The queue decouples item intake from row generation.
  i2cpg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  // Back end: the pixel store, the column walk and the output register.
  i2cpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o)
  );

endmodule

>>> design/i2cpg_front.sv
// ----------------------------------------------------------------------------
// i2cpg_front
// Holds the configuration registers, accepts items and turns them into
// queued load or row commands. Loads outside the image are dropped here.
// ----------------------------------------------------------------------------
module i2cpg_front
  import i2cpg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [SIZE_W-1:0]            cfg_data_i,
  output cfg_t                         cfg_o,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [PLANE_W-1:0]           plane_i,
  input  logic [ROW_W-1:0]             pixel_row_i,
  input  logic [COL_W-1:0]             pixel_col_i,
  input  logic signed [DATA_WIDTH-1:0] pixel_value_i,
  input  logic [YOUT_W-1:0]            out_row_i,
  input  logic [KER_W-1:0]             kernel_row_i,
  input  logic [KER_W-1:0]             kernel_col_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output cmd_t                         q_cmd_o
);

  cfg_t              cfg_q;
  logic [SIZE_W-1:0] h_eff;
  logic [SIZE_W-1:0] w_eff;
  logic [PROD_W-1:0] prod;
  logic signed [POS_W-1:0] iy;
  logic              plane_ok;
  logic              ker_ok;
  logic              load_ok;
  logic              row_ok;
  logic              is_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stride_w  <= STEP_W'(1);
      cfg_q.stride_h  <= STEP_W'(1);
      cfg_q.pad_w     <= '0;
      cfg_q.pad_h     <= '0;
      cfg_q.in_width  <= SIZE_W'(64);
      cfg_q.in_height <= SIZE_W'(64);
      cfg_q.out_width <= SIZE_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIDE_W:  cfg_q.stride_w  <= cfg_data_i[STEP_W-1:0];
        CFG_STRIDE_H:  cfg_q.stride_h  <= cfg_data_i[STEP_W-1:0];
        CFG_PAD_W:     cfg_q.pad_w     <= cfg_data_i[STEP_W-1:0];
        CFG_PAD_H:     cfg_q.pad_h     <= cfg_data_i[STEP_W-1:0];
        CFG_IN_WIDTH:  cfg_q.in_width  <= cfg_data_i;
        CFG_IN_HEIGHT: cfg_q.in_height <= cfg_data_i;
        CFG_OUT_WIDTH: cfg_q.out_width <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  assign h_eff = clamp_size(cfg_q.in_height, MAX_HEIGHT);
  assign w_eff = clamp_size(cfg_q.in_width, MAX_WIDTH);

  assign plane_ok = (int'(plane_i) < MAX_PLANES);
  assign ker_ok   = (int'(kernel_row_i) < MAX_KERNEL) && (int'(kernel_col_i) < MAX_KERNEL);

  // Input row of the request; it is fixed for the whole patch row.
  assign prod = PROD_W'(out_row_i) * PROD_W'(cfg_q.stride_h);
  assign iy   = $signed({1'b0, prod}) + $signed(POS_W'(kernel_row_i))
              - $signed(POS_W'(cfg_q.pad_h));
  assign row_ok = plane_ok && ker_ok && !iy[POS_W-1]
               && (iy[POS_W-2:0] < (POS_W-1)'(h_eff));

  assign load_ok = plane_ok && (SIZE_W'(pixel_row_i) < h_eff)
                && (SIZE_W'(pixel_col_i) < w_eff);

  assign is_req     = (kind_i == KIND_REQ);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && (is_req || load_ok);

  always_comb begin
    q_cmd_o.kind   = is_req ? KIND_REQ : KIND_LOAD;
    q_cmd_o.plane  = plane_i;
    q_cmd_o.row    = is_req ? iy[ROW_W-1:0] : pixel_row_i;
    q_cmd_o.col    = pixel_col_i;
    q_cmd_o.data   = pixel_value_i;
    q_cmd_o.row_ok = row_ok;
    q_cmd_o.kw     = kernel_col_i;
  end

endmodule

>>> design/i2cpg_queue.sv
// ----------------------------------------------------------------------------
// i2cpg_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module i2cpg_queue
  import i2cpg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/i2cpg_back.sv
// ----------------------------------------------------------------------------
// i2cpg_back
// Owns the pixel store. Writes load commands and walks the output columns of
// row commands, one store read a cycle while the output is not stalled,
// through a read stage and an output register.
// ----------------------------------------------------------------------------
module i2cpg_back
  import i2cpg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  q_head_t                      head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic [XOUT_W-1:0]            out_col_o,
  output logic                         last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } state_e;

  state_e                  state_q;
  logic [PLANE_W-1:0]      plane_q;
  logic [ROW_W-1:0]        row_q;
  logic                    row_ok_q;
  logic [XOUT_W-1:0]       x_q;
  logic [SIZE_W-1:0]       n_q;
  logic signed [POS_W-1:0] ix_q;

  logic                    s1_vld_q;
  logic                    s1_hit_q;
  logic                    s1_last_q;
  logic [XOUT_W-1:0]       s1_x_q;

  logic                    out_vld_q;
  logic signed [DATA_WIDTH-1:0] out_val_q;
  logic [XOUT_W-1:0]       out_col_q;
  logic                    out_last_q;

  logic signed [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata_q;

  logic [SIZE_W-1:0]       w_eff;
  logic [SIZE_W-1:0]       n_eff;
  logic                    s1_adv;
  logic                    issue;
  logic                    hit;
  logic                    x_last;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;

  assign w_eff = clamp_size(cfg_i.in_width, MAX_WIDTH);
  assign n_eff = clamp_size(cfg_i.out_width, MAX_OUT_W);

  assign s1_adv = s1_vld_q && (!out_vld_q || out_ready_i);
  assign issue  = (state_q == ST_ROW) && (!s1_vld_q || s1_adv);
  assign x_last = ((SIZE_W'(x_q) + 1'b1) == n_q);
  assign hit    = row_ok_q && !ix_q[POS_W-1] && (ix_q[POS_W-2:0] < (POS_W-1)'(w_eff));

  assign pop_o   = (state_q == ST_IDLE) && head_i.valid;
  assign wr_en   = pop_o && (head_i.cmd.kind == KIND_LOAD);
  assign wr_addr = {head_i.cmd.plane, head_i.cmd.row, head_i.cmd.col};
  assign rd_addr = {plane_q, row_q, ix_q[COL_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      plane_q    <= '0;
      row_q      <= '0;
      row_ok_q   <= 1'b0;
      x_q        <= '0;
      n_q        <= '0;
      ix_q       <= '0;
      s1_vld_q   <= 1'b0;
      s1_hit_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_x_q     <= '0;
      out_vld_q  <= 1'b0;
      out_val_q  <= '0;
      out_col_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && head_i.cmd.kind == KIND_REQ) begin
            plane_q  <= head_i.cmd.plane;
            row_q    <= head_i.cmd.row;
            row_ok_q <= head_i.cmd.row_ok;
            x_q      <= '0;
            n_q      <= n_eff;
            ix_q     <= $signed(POS_W'(head_i.cmd.kw)) - $signed(POS_W'(cfg_i.pad_w));
            if (n_eff != '0) begin
              state_q <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          if (issue) begin
            x_q  <= x_q + 1'b1;
            ix_q <= ix_q + $signed(POS_W'(cfg_i.stride_w));
            if (x_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Read stage: the store data arrives with it.
      if (issue) begin
        s1_vld_q  <= 1'b1;
        s1_hit_q  <= hit;
        s1_last_q <= x_last;
        s1_x_q    <= x_q;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end

      // Output register.
      if (s1_adv) begin
        out_vld_q  <= 1'b1;
        out_val_q  <= s1_hit_q ? rdata_q : '0;
        out_col_q  <= s1_x_q;
        out_last_q <= s1_last_q;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= head_i.cmd.data;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = out_val_q;
  assign out_col_o   = out_col_q;
  assign last_o      = out_last_q;

endmodule

>>> tb/im2col_checker.sv
// ----------------------------------------------------------------------------
// im2col_checker
// Watches the patch gather block and checks every gathered value it delivers.
// ----------------------------------------------------------------------------
// Keeps its own copy of the geometry registers and of the pixel store. For
// each accepted row request it works out the values that the block must
// produce, then compares them in order with the values it delivers.
// ----------------------------------------------------------------------------
module im2col_checker
  import i2cpg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [SIZE_W-1:0]            cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         kind_i,
  input  logic [PLANE_W-1:0]           plane_i,
  input  logic [ROW_W-1:0]             pixel_row_i,
  input  logic [COL_W-1:0]             pixel_col_i,
  input  logic signed [DATA_WIDTH-1:0] pixel_value_i,
  input  logic [YOUT_W-1:0]            out_row_i,
  input  logic [KER_W-1:0]             kernel_row_i,
  input  logic [KER_W-1:0]             kernel_col_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic [XOUT_W-1:0]            out_col_i,
  input  logic                         last_i,
  output int                           mismatches_o,
  output int                           values_due_o
);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [XOUT_W-1:0]            col;
    logic                         last;
  } gathered_t;

  cfg_t                         geom;
  logic signed [DATA_WIDTH-1:0] pixel_copy [STORE_DEPTH];
  gathered_t                    due_values [$];
  int                           mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int clip(input int v, input int lim);
    return (v < lim) ? v : lim;
  endfunction

  task automatic store_pixel(input logic [PLANE_W-1:0]           plane,
                             input logic [ROW_W-1:0]             row,
                             input logic [COL_W-1:0]             col,
                             input logic signed [DATA_WIDTH-1:0] value);
    if (int'(plane) < MAX_PLANES && int'(row) < clip(int'(geom.in_height), MAX_HEIGHT)
        && int'(col) < clip(int'(geom.in_width), MAX_WIDTH))
      pixel_copy[(int'(plane) * MAX_HEIGHT + int'(row)) * MAX_WIDTH + int'(col)] = value;
  endtask

  // One patch row: the input row is fixed by the request, the input column
  // steps by stride_w for each output column. Anything outside the image is
  // padding and reads as zero.
  task automatic gather_row(input logic [PLANE_W-1:0] plane,
                            input logic [YOUT_W-1:0]  y,
                            input logic [KER_W-1:0]   kh,
                            input logic [KER_W-1:0]   kw);
    int        h;
    int        w;
    int        n;
    int        iy;
    int        ix;
    bit        row_ok;
    gathered_t g;
    h  = clip(int'(geom.in_height), MAX_HEIGHT);
    w  = clip(int'(geom.in_width), MAX_WIDTH);
    n  = clip(int'(geom.out_width), MAX_OUT_W);
    iy = int'(y) * int'(geom.stride_h) - int'(geom.pad_h) + int'(kh);
    row_ok = int'(plane) < MAX_PLANES && int'(kh) < MAX_KERNEL && int'(kw) < MAX_KERNEL
             && iy >= 0 && iy < h;
    for (int x = 0; x < n; x++) begin
      ix      = x * int'(geom.stride_w) - int'(geom.pad_w) + int'(kw);
      g.value = '0;
      if (row_ok && ix >= 0 && ix < w)
        g.value = pixel_copy[(int'(plane) * MAX_HEIGHT + iy) * MAX_WIDTH + ix];
      g.col  = XOUT_W'(x);
      g.last = (x == n - 1);
      due_values.push_back(g);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gathered_t want;
    if (!rst_ni) begin
      geom = '{stride_w: 1, stride_h: 1, pad_w: 0, pad_h: 0,
               in_width: 64, in_height: 64, out_width: 64};
      due_values.delete();
      values_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_STRIDE_W:  geom.stride_w  = cfg_data_i[STEP_W-1:0];
          CFG_STRIDE_H:  geom.stride_h  = cfg_data_i[STEP_W-1:0];
          CFG_PAD_W:     geom.pad_w     = cfg_data_i[STEP_W-1:0];
          CFG_PAD_H:     geom.pad_h     = cfg_data_i[STEP_W-1:0];
          CFG_IN_WIDTH:  geom.in_width  = cfg_data_i;
          CFG_IN_HEIGHT: geom.in_height = cfg_data_i;
          CFG_OUT_WIDTH: geom.out_width = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_e'(kind_i) == KIND_LOAD)
          store_pixel(plane_i, pixel_row_i, pixel_col_i, pixel_value_i);
        else
          gather_row(plane_i, out_row_i, kernel_row_i, kernel_col_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (due_values.size() == 0) begin
          flag_mismatch($sformatf("unexpected value %0d at column %0d", value_i, out_col_i));
        end else begin
          want = due_values.pop_front();
          if (value_i !== want.value)
            flag_mismatch($sformatf("column %0d: value %0d, wanted %0d",
                                    want.col, value_i, want.value));
          if (out_col_i !== want.col)
            flag_mismatch($sformatf("column index %0d, wanted %0d", out_col_i, want.col));
          if (last_i !== want.last)
            flag_mismatch($sformatf("column %0d: last %0b, wanted %0b",
                                    want.col, last_i, want.last));
        end
      end
      values_due_o <= due_values.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the im2col patch gather block.
// ----------------------------------------------------------------------------
// Runs directed items through a series of geometry settings (the extremes,
// clipped sizes, a zero stride, empty images and an empty row) and finally
// random phases of loads and row requests on small images. Before each row
// request, every pixel it will read that has not been loaded yet is loaded,
// so the store is never read where nothing was written. Both channels idle
// at random and the receiver holds off once for a long stretch. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cpg_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  // Once nothing is due, at most a queue full of loads or empty rows remains.
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 600;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 12;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [2:0]                   cfg_idx_i;
  logic [SIZE_W-1:0]            cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         kind_i;
  logic [PLANE_W-1:0]           plane_i;
  logic [ROW_W-1:0]             pixel_row_i;
  logic [COL_W-1:0]             pixel_col_i;
  logic signed [DATA_WIDTH-1:0] pixel_value_i;
  logic [YOUT_W-1:0]            out_row_i;
  logic [KER_W-1:0]             kernel_row_i;
  logic [KER_W-1:0]             kernel_col_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [DATA_WIDTH-1:0] value_o;
  logic [XOUT_W-1:0]            out_col_o;
  logic                         last_o;

  int   mismatches;
  int   values_due;
  int   cycle_count = 0;

  // The geometry that the stimulus last wrote; it steers the random rows.
  cfg_t geometry;
  // Pixels that a load has stored since reset.
  bit   written [STORE_DEPTH];
  // While calm is set the sender offers items back to back.
  bit   calm;
  // Raised by the stimulus to ask for one long hold-off of the receiver.
  bit   long_hold_req;
  bit   long_hold_done;

  im2col_patch_gather u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .plane_i, .pixel_row_i, .pixel_col_i,
    .pixel_value_i, .out_row_i, .kernel_row_i, .kernel_col_i,
    .out_valid_o, .out_ready_i, .value_o, .out_col_o, .last_o
  );

  im2col_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i (in_ready_o), .kind_i, .plane_i, .pixel_row_i,
    .pixel_col_i, .pixel_value_i, .out_row_i, .kernel_row_i, .kernel_col_i,
    .out_valid_i (out_valid_o), .out_ready_i, .value_i (value_o),
    .out_col_i (out_col_o), .last_i (last_o),
    .mismatches_o (mismatches), .values_due_o (values_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A run that hangs, or that leaves values due for ever, ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clip(input int v, input int lim);
    return (v < lim) ? v : lim;
  endfunction

  function automatic int pixel_index(input int plane, input int row, input int col);
    return (plane * MAX_HEIGHT + row) * MAX_WIDTH + col;
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid is
  // left high, so that the next item can follow without a gap; it is only
  // lowered when a gap is wanted.
  task automatic push_item(input kind_e                        kind,
                           input logic [PLANE_W-1:0]           plane,
                           input logic [ROW_W-1:0]             row,
                           input logic [COL_W-1:0]             col,
                           input logic signed [DATA_WIDTH-1:0] value,
                           input logic [YOUT_W-1:0]            y,
                           input logic [KER_W-1:0]             kh,
                           input logic [KER_W-1:0]             kw);
    int gap;
    gap = calm ? 0 : idle_span();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    plane_i       <= plane;
    pixel_row_i   <= row;
    pixel_col_i   <= col;
    pixel_value_i <= value;
    out_row_i     <= y;
    kernel_row_i  <= kh;
    kernel_col_i  <= kw;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // The fields that an item does not use carry random junk, which the block
  // must ignore. A load inside the current image is remembered as stored.
  task automatic load_pixel(input int plane, input int row, input int col,
                            input int value);
    int h;
    int w;
    h = clip(int'(geometry.in_height), MAX_HEIGHT);
    w = clip(int'(geometry.in_width), MAX_WIDTH);
    push_item(KIND_LOAD, PLANE_W'(plane), ROW_W'(row), COL_W'(col), DATA_WIDTH'(value),
              YOUT_W'($urandom), KER_W'($urandom), KER_W'($urandom));
    if (row < h && col < w) written[pixel_index(plane, row, col)] = 1'b1;
  endtask

  // Loads whatever pixels the row will read and are still unwritten, then
  // offers the request itself.
  task automatic ask_row(input int plane, input int y, input int kh, input int kw);
    int h;
    int w;
    int n;
    int iy;
    int ix;
    h  = clip(int'(geometry.in_height), MAX_HEIGHT);
    w  = clip(int'(geometry.in_width), MAX_WIDTH);
    n  = clip(int'(geometry.out_width), MAX_OUT_W);
    iy = y * int'(geometry.stride_h) - int'(geometry.pad_h) + kh;
    if (iy >= 0 && iy < h) begin
      for (int x = 0; x < n; x++) begin
        ix = x * int'(geometry.stride_w) - int'(geometry.pad_w) + kw;
        if (ix >= 0 && ix < w && !written[pixel_index(plane, iy, ix)])
          load_pixel(plane, iy, ix, $urandom);
      end
    end
    push_item(KIND_REQ, PLANE_W'(plane), ROW_W'($urandom), COL_W'($urandom),
              DATA_WIDTH'($urandom), YOUT_W'(y), KER_W'(kh), KER_W'(kw));
  endtask

  // Stops offering items and waits until every value due has arrived. At
  // least one edge passes, so that valid is never lowered and raised again
  // in the same step.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (values_due != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SIZE_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic set_geometry(input int sw, input int sh, input int pw, input int ph,
                              input int iw, input int ih, input int ow);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_STRIDE_W,  SIZE_W'(sw));
    write_reg(CFG_STRIDE_H,  SIZE_W'(sh));
    write_reg(CFG_PAD_W,     SIZE_W'(pw));
    write_reg(CFG_PAD_H,     SIZE_W'(ph));
    write_reg(CFG_IN_WIDTH,  SIZE_W'(iw));
    write_reg(CFG_IN_HEIGHT, SIZE_W'(ih));
    write_reg(CFG_OUT_WIDTH, SIZE_W'(ow));
    cfg_we_i <= 1'b0;
    geometry = '{stride_w: STEP_W'(sw), stride_h: STEP_W'(sh), pad_w: STEP_W'(pw),
                 pad_h: STEP_W'(ph), in_width: SIZE_W'(iw), in_height: SIZE_W'(ih),
                 out_width: SIZE_W'(ow)};
  endtask

  // Half of the random loads land inside the image. Most random requests
  // pick an output row whose input row lies inside the image, so that real
  // pixels are gathered; the rest range over every row.
  task automatic random_item();
    int h;
    int w;
    int span;
    h = clip(int'(geometry.in_height), MAX_HEIGHT);
    w = clip(int'(geometry.in_width), MAX_WIDTH);
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 1) == 0 && h > 0 && w > 0)
        load_pixel($urandom_range(0, MAX_PLANES - 1), $urandom_range(0, h - 1),
                   $urandom_range(0, w - 1), $urandom);
      else
        load_pixel($urandom_range(0, MAX_PLANES - 1), $urandom_range(0, MAX_HEIGHT - 1),
                   $urandom_range(0, MAX_WIDTH - 1), $urandom);
    end else begin
      span = (h + int'(geometry.pad_h))
             / ((geometry.stride_h == 0) ? 1 : int'(geometry.stride_h));
      if (span > 127 || $urandom_range(0, 99) < 30) span = 127;
      ask_row($urandom_range(0, MAX_PLANES - 1), $urandom_range(0, span),
              $urandom_range(0, 15), $urandom_range(0, 15));
    end
  endtask

  // Receiver: bursts of readiness broken by idle gaps, with the odd long
  // stretch of no idling at all, and one long hold-off on request.
  initial begin : receiver
    int hi;
    int lo;
    out_ready_i    <= 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        out_ready_i <= 1'b1;
        repeat (hi) @(posedge clk_i);
        lo = idle_span();
        if (lo > 0) begin
          out_ready_i <= 1'b0;
          repeat (lo) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int iw;
    int ih;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_STRIDE_W;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_LOAD;
    plane_i       <= '0;
    pixel_row_i   <= '0;
    pixel_col_i   <= '0;
    pixel_value_i <= '0;
    out_row_i     <= '0;
    kernel_row_i  <= '0;
    kernel_col_i  <= '0;
    calm          = 1'b1;
    long_hold_req = 1'b0;
    geometry      = '{stride_w: 1, stride_h: 1, pad_w: 0, pad_h: 0,
                      in_width: 64, in_height: 64, out_width: 64};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1'b0;

    // Full-size image read at a wide column step: extreme pixel values, the
    // corners, and a row that falls wholly below the image.
    set_geometry(16, 1, 0, 0, 64, 64, 4);
    load_pixel(3, 63, 63, 32767);
    load_pixel(0, 0, 0, -32768);
    ask_row(0, 0, 0, 0);
    ask_row(3, 63, 0, 15);
    ask_row(2, 127, 15, 15);

    // Strides and padding of 16 on a full-size image.
    set_geometry(16, 16, 16, 16, 64, 64, 64);
    ask_row(1, 0, 0, 0);
    ask_row(1, 1, 15, 15);
    ask_row(3, 4, 15, 0);

    // A small image: loads beyond its bottom or right edge are dropped.
    set_geometry(2, 3, 1, 2, 20, 13, 17);
    load_pixel(2, 13, 0, 1234);
    load_pixel(2, 0, 20, -1);
    load_pixel(2, 12, 19, 23130);
    ask_row(2, 4, 2, 0);

    // Zero strides sample one position throughout; the oversized sizes are
    // clipped to the store.
    set_geometry(0, 0, 0, 3, 127, 100, 127);
    load_pixel(1, 63, 63, -2);
    ask_row(1, 127, 5, 7);
    ask_row(1, 22, 15, 15);

    // An image of no width: everything is padding and loads are dropped.
    set_geometry(1, 1, 0, 0, 0, 5, 9);
    load_pixel(0, 0, 0, 77);
    ask_row(0, 0, 0, 0);

    // No output columns at all, and an image of no height.
    set_geometry(1, 1, 0, 0, 7, 0, 0);
    ask_row(0, 0, 0, 0);
    load_pixel(0, 1, 1, 5);
    ask_row(3, 2, 1, 1);

    // Every register bit set: single-column rows deep in the padding.
    set_geometry(31, 31, 31, 31, 64, 64, 1);
    ask_row(0, 1, 15, 15);
    ask_row(3, 2, 0, 15);

    // Long rows below the image against a receiver that stops taking
    // values, so that the command queue fills and the input side stalls.
    set_geometry(1, 1, 0, 0, 64, 64, 64);
    long_hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      ask_row($urandom_range(0, MAX_PLANES - 1), $urandom_range(64, 112),
              $urandom_range(0, 15), $urandom_range(0, 15));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm = ($urandom_range(0, 3) == 0);
      iw   = $urandom_range(1, 8);
      ih   = $urandom_range(1, 8);
      set_geometry($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 16),
                   $urandom_range(0, 16), iw, ih, $urandom_range(1, 64));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Halfway through one phase the sender waits for the block to empty.
        if (phase == 2 && i == PHASE_ITEMS / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && values_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
